FILE: sv/blca_pkg.sv
// ---------------------------------------------------------------------------
// blca_pkg: shared types and constants for the LCA query unit
// Table geometry, request action codes and the structs between blocks.
// ---------------------------------------------------------------------------
package blca_pkg;

    // Field widths
    localparam int NODE_W   = 10;
    localparam int DEPTH_W  = 10;
    localparam int ACTION_W = 2;
    localparam int STEP_W   = 4;

    // Tree geometry
    localparam int NODE_COUNT  = 1 << NODE_W;
    localparam int JUMP_LEVELS = 10;
    localparam int LEVEL_W     = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;

    // Ancestor table is addressed as {node, level}
    localparam int ANC_AW    = NODE_W + LEVEL_W;
    localparam int ANC_DEPTH = 1 << ANC_AW;

    localparam logic [STEP_W:0]    STEP_LIMIT = (STEP_W + 1)'(JUMP_LEVELS);
    localparam logic [LEVEL_W-1:0] LEVEL_TOP  = LEVEL_W'(JUMP_LEVELS - 1);

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_ANC_WR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DEP_WR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

    typedef struct packed {
        logic              we;
        logic [ANC_AW-1:0] addr;
        logic [NODE_W-1:0] wdata;
    } anc_cmd_t;

    typedef struct packed {
        logic               we;
        logic [NODE_W-1:0]  addr;
        logic [DEPTH_W-1:0] wdata;
    } dep_cmd_t;

    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] common_ancestor;
        logic              depth_consistent;
    } res_t;

endpackage

FILE: sv/blca_if.sv
// ---------------------------------------------------------------------------
// blca_if: request and response channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ---------------------------------------------------------------------------
interface blca_req_if
    import blca_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [STEP_W-1:0]   step;
    logic [NODE_W-1:0]   entry_value;

    modport source (output valid, action, node_a, node_b, step, entry_value,
                    input ready);
    modport sink   (input valid, action, node_a, node_b, step, entry_value,
                    output ready);
endinterface

interface blca_rsp_if
    import blca_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] common_ancestor;
    logic              depth_consistent;

    modport source (output valid, common_ancestor, depth_consistent,
                    input ready);
    modport sink   (input valid, common_ancestor, depth_consistent,
                    output ready);
endinterface

FILE: sv/blca_ram.sv
// ---------------------------------------------------------------------------
// blca_ram: single-port RAM
// One read or write per cycle, registered read data.
// ---------------------------------------------------------------------------
module blca_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: sv/blca_engine.sv
// ---------------------------------------------------------------------------
// blca_engine: query sequencer
// Runs table loads and walks both lifting loops over the two table ports.
// ---------------------------------------------------------------------------
module blca_engine
    import blca_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    blca_req_if.sink           req,
    output anc_cmd_t           anc_cmd,
    input  logic [NODE_W-1:0]  anc_rdata,
    output dep_cmd_t           dep_cmd,
    input  logic [DEPTH_W-1:0] dep_rdata,
    output res_t               res,
    input  logic               res_take
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_DB,
        S_ORDER,
        S_L1_ANC,
        S_L1_DEP,
        S_L1_CMP,
        S_CHECK,
        S_L2_SH,
        S_L2_DP,
        S_L2_CMP,
        S_FIN_RD,
        S_FIN,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [LEVEL_W-1:0] k_reg, k_next;
    logic [NODE_W-1:0]  shallow_reg, shallow_next;
    logic [NODE_W-1:0]  deep_reg, deep_next;
    logic [DEPTH_W-1:0] dshal_reg, dshal_next;
    logic [DEPTH_W-1:0] ddeep_reg, ddeep_next;
    logic [DEPTH_W-1:0] da_reg, da_next;
    logic [NODE_W-1:0]  tmp_reg, tmp_next;      // lifted node or shallow-side ancestor
    logic [NODE_W-1:0]  answer_reg, answer_next;
    logic               cons_reg, cons_next;

    assign req.ready = (state_reg == S_IDLE);

    assign res.valid            = (state_reg == S_DONE);
    assign res.common_ancestor  = answer_reg;
    assign res.depth_consistent = cons_reg;

    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        shallow_next = shallow_reg;
        deep_next    = deep_reg;
        dshal_next   = dshal_reg;
        ddeep_next   = ddeep_reg;
        da_next      = da_reg;
        tmp_next     = tmp_reg;
        answer_next  = answer_reg;
        cons_next    = cons_reg;
        anc_cmd      = '0;
        dep_cmd      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    unique case (req.action)
                        ACT_ANC_WR:
                        begin
                            if ({1'b0, req.step} < STEP_LIMIT)
                            begin
                                anc_cmd.we    = 1'b1;
                                anc_cmd.addr  = {req.node_a, req.step[LEVEL_W-1:0]};
                                anc_cmd.wdata = req.entry_value;
                            end
                        end
                        ACT_DEP_WR:
                        begin
                            dep_cmd.we    = 1'b1;
                            dep_cmd.addr  = req.node_a;
                            dep_cmd.wdata = req.entry_value;
                        end
                        ACT_QUERY:
                        begin
                            dep_cmd.addr = req.node_a;
                            shallow_next = req.node_a;
                            deep_next    = req.node_b;
                            state_next   = S_RD_DB;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD_DB:
            begin
                da_next      = dep_rdata;
                dep_cmd.addr = deep_reg;
                state_next   = S_ORDER;
            end
            S_ORDER:
            begin
                // node_a deeper: swap roles
                if (da_reg > dep_rdata)
                begin
                    shallow_next = deep_reg;
                    deep_next    = shallow_reg;
                    dshal_next   = dep_rdata;
                    ddeep_next   = da_reg;
                end
                else
                begin
                    dshal_next = da_reg;
                    ddeep_next = dep_rdata;
                end
                k_next     = LEVEL_TOP;
                state_next = S_L1_ANC;
            end
            S_L1_ANC:
            begin
                anc_cmd.addr = {deep_reg, k_reg};
                state_next   = S_L1_DEP;
            end
            S_L1_DEP:
            begin
                tmp_next     = anc_rdata;
                dep_cmd.addr = anc_rdata;
                state_next   = S_L1_CMP;
            end
            S_L1_CMP:
            begin
                if (dep_rdata >= dshal_reg)
                begin
                    deep_next  = tmp_reg;
                    ddeep_next = dep_rdata;
                end
                if (k_reg == '0)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = S_L1_ANC;
                end
            end
            S_CHECK:
            begin
                cons_next = (ddeep_reg == dshal_reg);
                if (shallow_reg == deep_reg)
                begin
                    answer_next = shallow_reg;
                    state_next  = S_DONE;
                end
                else
                begin
                    k_next     = LEVEL_TOP;
                    state_next = S_L2_SH;
                end
            end
            S_L2_SH:
            begin
                anc_cmd.addr = {shallow_reg, k_reg};
                state_next   = S_L2_DP;
            end
            S_L2_DP:
            begin
                tmp_next     = anc_rdata;
                anc_cmd.addr = {deep_reg, k_reg};
                state_next   = S_L2_CMP;
            end
            S_L2_CMP:
            begin
                if (tmp_reg != anc_rdata)
                begin
                    shallow_next = tmp_reg;
                    deep_next    = anc_rdata;
                end
                if (k_reg == '0)
                begin
                    state_next = S_FIN_RD;
                end
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = S_L2_SH;
                end
            end
            S_FIN_RD:
            begin
                anc_cmd.addr = {shallow_reg, {LEVEL_W{1'b0}}};
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                answer_next = anc_rdata;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            k_reg       <= '0;
            shallow_reg <= '0;
            deep_reg    <= '0;
            dshal_reg   <= '0;
            ddeep_reg   <= '0;
            da_reg      <= '0;
            tmp_reg     <= '0;
            answer_reg  <= '0;
            cons_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            shallow_reg <= shallow_next;
            deep_reg    <= deep_next;
            dshal_reg   <= dshal_next;
            ddeep_reg   <= ddeep_next;
            da_reg      <= da_next;
            tmp_reg     <= tmp_next;
            answer_reg  <= answer_next;
            cons_reg    <= cons_next;
        end
    end

endmodule

FILE: sv/binary_lifting_lca_query_unit.sv
// ---------------------------------------------------------------------------
// binary_lifting_lca_query_unit: lowest common ancestor by binary lifting
// Loads a depth table and an ancestor table, answers two-node queries.
// ---------------------------------------------------------------------------
// Loads are written when accepted and may follow back to back; they give no response.
// A query reads both depths and runs the first lifting loop and the check; the second
//   loop and the final parent read follow unless the lifted node equals the shallower one.
// Each lifting step runs an address, a read and a compare state; ready returns in the
//   same cycle that the response is registered, so queries never overlap.
// Async active-low reset clears registers only; tables undefined until written.
module binary_lifting_lca_query_unit
    import blca_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    blca_req_if.sink   req,
    blca_rsp_if.source rsp
);

    anc_cmd_t           anc_cmd;
    dep_cmd_t           dep_cmd;
    logic [NODE_W-1:0]  anc_rdata;
    logic [DEPTH_W-1:0] dep_rdata;
    res_t               res;
    logic               res_take;

    logic              out_valid_reg, out_valid_next;
    logic [NODE_W-1:0] out_ca_reg, out_ca_next;
    logic              out_dc_reg, out_dc_next;

    // Ancestor table: address {node, level}; one entry per jump of a node
    blca_ram #(
        .WIDTH (NODE_W),
        .DEPTH (ANC_DEPTH)
    ) u_anc_ram (
        .clk   (clk),
        .we    (anc_cmd.we),
        .addr  (anc_cmd.addr),
        .wdata (anc_cmd.wdata),
        .rdata (anc_rdata)
    );

    // Depth table: one depth per node
    blca_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (NODE_COUNT)
    ) u_dep_ram (
        .clk   (clk),
        .we    (dep_cmd.we),
        .addr  (dep_cmd.addr),
        .wdata (dep_cmd.wdata),
        .rdata (dep_rdata)
    );

    // Sequencer: owns the handshake on req and both table ports
    blca_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .anc_cmd   (anc_cmd),
        .anc_rdata (anc_rdata),
        .dep_cmd   (dep_cmd),
        .dep_rdata (dep_rdata),
        .res       (res),
        .res_take  (res_take)
    );

    // Response register: takes the result when empty or draining; a stalled sink holds the engine
    assign res_take = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_ca_next    = out_ca_reg;
        out_dc_next    = out_dc_reg;
        if (res.valid && res_take)
        begin
            out_valid_next = 1'b1;
            out_ca_next    = res.common_ancestor;
            out_dc_next    = res.depth_consistent;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_ca_reg    <= '0;
            out_dc_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_ca_reg    <= out_ca_next;
            out_dc_reg    <= out_dc_next;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.common_ancestor  = out_ca_reg;
    assign rsp.depth_consistent = out_dc_reg;

endmodule

FILE: sv/blca_checker.sv
// ---------------------------------------------------------------------------
// blca_checker: port-level checks for the LCA query unit
// Tracks outstanding queries and checks busy and response behavior.
// ---------------------------------------------------------------------------
module blca_checker
    import blca_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic [ACTION_W-1:0] in_action,
    input logic                out_valid,
    input logic                out_ready,
    input logic [NODE_W-1:0]   out_ca,
    input logic                out_dc
);

    logic       q_acc;
    logic       ld_acc;
    logic       r_acc;
    logic [1:0] pend_reg;

    assign q_acc  = in_valid && in_ready && (in_action == ACT_QUERY);
    assign ld_acc = in_valid && in_ready &&
                    ((in_action == ACT_ANC_WR) || (in_action == ACT_DEP_WR));
    assign r_acc  = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + {1'b0, q_acc} - {1'b0, r_acc};
        end
    end

    // Stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_ca) && $stable(out_dc))
        else $error("response changed while stalled");

    // Query keeps the unit busy
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_acc |=> !in_ready)
        else $error("ready right after query accept");

    // Loads leave the unit ready
    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        ld_acc |=> in_ready)
        else $error("load did not complete in one cycle");

    // No response without an outstanding query
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("response without query");

endmodule

bind binary_lifting_lca_query_unit blca_checker u_blca_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_action (req.action),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_ca    (rsp.common_ancestor),
    .out_dc    (rsp.depth_consistent)
);

FILE: sim/lca_answer_checker.sv
// ---------------------------------------------------------------------------
// lca_answer_checker: predicts and checks answers of the LCA query unit
// Mirrors both tables from accepted load requests, computes the expected
// answer of each accepted query and compares it with the response stream.
// ---------------------------------------------------------------------------
module lca_answer_checker
    import blca_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    blca_req_if  req,
    blca_rsp_if  rsp,
    output int   fail_count,
    output int   open_queries,
    output int   answered,
    output int   flagged
);

    typedef struct packed {
        logic [NODE_W-1:0] ancestor;
        logic              consistent;
    } lca_answer_t;

    logic [NODE_W-1:0]  jump_to  [NODE_COUNT][JUMP_LEVELS];
    logic [DEPTH_W-1:0] depth_of [NODE_COUNT];
    lca_answer_t        lca_expected [$];

    // Lift the deeper node to the shallower depth, then lift both while
    // their ancestors differ; the first loop always runs every level, the second unless the nodes already match.
    function automatic lca_answer_t lca_of(input logic [NODE_W-1:0] a,
                                           input logic [NODE_W-1:0] b);
        logic [NODE_W-1:0] near;
        logic [NODE_W-1:0] far;
        logic [NODE_W-1:0] up_near;
        logic [NODE_W-1:0] up_far;
        lca_answer_t       ans;
        near = a;
        far  = b;
        if (depth_of[a] > depth_of[b])
        begin
            near = b;
            far  = a;
        end
        for (int k = JUMP_LEVELS - 1; k >= 0; k--)
        begin
            if (depth_of[jump_to[far][k]] >= depth_of[near])
                far = jump_to[far][k];
        end
        ans.consistent = (depth_of[far] == depth_of[near]);
        if (near == far)
            ans.ancestor = near;
        else
        begin
            for (int k = JUMP_LEVELS - 1; k >= 0; k--)
            begin
                up_near = jump_to[near][k];
                up_far  = jump_to[far][k];
                if (up_near != up_far)
                begin
                    near = up_near;
                    far  = up_far;
                end
            end
            ans.ancestor = jump_to[near][0];
        end
        return ans;
    endfunction

    always @(posedge clk)
    begin
        lca_answer_t want;
        if (rst_n)
        begin
            // response first: a query accepted at this edge cannot answer here
            if (rsp.valid && rsp.ready)
            begin
                if (lca_expected.size() == 0)
                begin
                    $display("%0t: response with no query waiting: expected none, got %0d/%0b",
                             $time, rsp.common_ancestor, rsp.depth_consistent);
                    fail_count++;
                end
                else
                begin
                    want = lca_expected.pop_front();
                    if (rsp.common_ancestor !== want.ancestor)
                    begin
                        $display("%0t: common_ancestor expected %0d, got %0d",
                                 $time, want.ancestor, rsp.common_ancestor);
                        fail_count++;
                    end
                    if (rsp.depth_consistent !== want.consistent)
                    begin
                        $display("%0t: depth_consistent expected %0b, got %0b",
                                 $time, want.consistent, rsp.depth_consistent);
                        fail_count++;
                    end
                    answered++;
                    if (!want.consistent)
                        flagged++;
                end
            end
            if (req.valid && req.ready)
            begin
                case (req.action)
                    ACT_ANC_WR:
                    begin
                        if (req.step < JUMP_LEVELS)
                            jump_to[req.node_a][req.step] = req.entry_value;
                    end
                    ACT_DEP_WR:
                        depth_of[req.node_a] = req.entry_value;
                    ACT_QUERY:
                        lca_expected = {lca_expected, lca_of(req.node_a, req.node_b)};
                    default:
                    begin
                    end
                endcase
            end
            open_queries = lca_expected.size();
        end
    end

endmodule

FILE: sim/testbench.sv
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for binary_lifting_lca_query_unit
// Loads a random base tree, runs directed corner requests, then random
// subtree rebuilds, queries and stray writes with random idling on both
// channels; the checker beside the block scores every answer.
// ---------------------------------------------------------------------------
module testbench;
    import blca_pkg::*;

    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all
    localparam int TAIL_CYCLES  = 80;    // longer than one query period
    localparam int RANDOM_ITEMS = 900;
    localparam int BASE_NODES   = 64;

    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(BASE_NODES - 1);

    // the block ignores this action; no package name exists for it
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    blca_req_if req_ch ();
    blca_rsp_if rsp_ch ();

    binary_lifting_lca_query_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    int fail_count;
    int open_queries;
    int answered;
    int flagged;

    lca_answer_checker answer_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .fail_count   (fail_count),
        .open_queries (open_queries),
        .answered     (answered),
        .flagged      (flagged)
    );

    // Stimulus-side picture of the tree: only used to make well-formed
    // loads and meaningful query pairs, never to predict answers.
    logic [NODE_W-1:0]  tree_up    [NODE_COUNT][JUMP_LEVELS];
    logic [DEPTH_W-1:0] tree_depth [NODE_COUNT];

    // nodes whose depth and full ancestor row have been loaded
    bit                known      [NODE_COUNT];
    logic [NODE_W-1:0] known_list [$];

    bit steady;        // 1: no idling on either side
    int ready_stall;
    int idle_cycles;
    int requests;
    int loads;
    int queries;
    int useful_items;  // requests the block does not simply drop
    int episodes;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // mostly no gap, often short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Response side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (ready_stall > 0)
        begin
            rsp_ch.ready <= 1'b0;
            ready_stall  <= ready_stall - 1;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            if (!steady && $urandom_range(0, 5) == 0)
                ready_stall <= pick_gap();
        end
    end

    // Watchdog: the run dies if nothing moves for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    // One request: optional gap first, then hold valid until accepted.
    // Returns at the accepting edge with valid still high.
    task automatic send_request(input logic [ACTION_W-1:0] act,
                                input logic [NODE_W-1:0]   a,
                                input logic [NODE_W-1:0]   b,
                                input logic [STEP_W-1:0]   stp,
                                input logic [NODE_W-1:0]   val);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.action      <= act;
        req_ch.node_a      <= a;
        req_ch.node_b      <= b;
        req_ch.step        <= stp;
        req_ch.entry_value <= val;
        req_ch.valid       <= 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        requests++;
        if (act == ACT_QUERY)
            queries++;
        else if (act != ACT_UNUSED)
            loads++;
        if (!(act == ACT_UNUSED || (act == ACT_ANC_WR && stp >= JUMP_LEVELS)))
            useful_items++;
    endtask

    // Sender holds off until every query in flight has been answered
    task automatic drain_answers();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (open_queries != 0)
            @(posedge clk);
    endtask

    function automatic void make_root(input logic [NODE_W-1:0]  x,
                                      input logic [DEPTH_W-1:0] d);
        tree_depth[x] = d;
        for (int k = 0; k < JUMP_LEVELS; k++)
            tree_up[x][k] = x;
    endfunction

    // parent must already have its full ancestor row
    function automatic void link(input logic [NODE_W-1:0] x,
                                 input logic [NODE_W-1:0] par);
        tree_depth[x] = tree_depth[par] + 1'b1;
        tree_up[x][0] = par;
        for (int k = 1; k < JUMP_LEVELS; k++)
            tree_up[x][k] = tree_up[tree_up[x][k-1]][k-1];
    endfunction

    // jump up by the set bits of hops
    function automatic logic [NODE_W-1:0] climb(input logic [NODE_W-1:0] x,
                                                input int hops);
        for (int k = 0; k < JUMP_LEVELS; k++)
        begin
            if (hops[k])
                x = tree_up[x][k];
        end
        return x;
    endfunction

    // any node whose row is fully loaded
    function automatic logic [NODE_W-1:0] pick_known();
        return known_list[$urandom_range(0, known_list.size() - 1)];
    endfunction

    // depth plus the whole ancestor row of one node; unused fields random
    task automatic load_node(input logic [NODE_W-1:0] x);
        send_request(ACT_DEP_WR, x, NODE_W'($urandom), STEP_W'($urandom),
                     tree_depth[x]);
        for (int k = 0; k < JUMP_LEVELS; k++)
            send_request(ACT_ANC_WR, x, NODE_W'($urandom), STEP_W'(k), tree_up[x][k]);
        if (!known[x])
        begin
            known[x]   = 1'b1;
            known_list = {known_list, x};
        end
    endtask

    // query a against a relative, itself, something near other, or other
    task automatic ask_pair(input logic [NODE_W-1:0] a,
                            input logic [NODE_W-1:0] other);
        logic [NODE_W-1:0] b;
        case ($urandom_range(0, 4))
            0:       b = climb(a, $urandom_range(0, NODE_COUNT - 1));
            1:       b = a;
            2:       b = climb(other, $urandom_range(0, 7));
            default: b = other;
        endcase
        if ($urandom_range(0, 1))
            send_request(ACT_QUERY, a, b, STEP_W'($urandom), NODE_W'($urandom));
        else
            send_request(ACT_QUERY, b, a, STEP_W'($urandom), NODE_W'($urandom));
    endtask

    // Base tree on nodes 0 .. BASE_NODES-1, each with a full row, so that
    // queries always have defined nodes to pick from. Parent is i-1 or
    // i-2: a few dozen levels deep and still branchy.
    task automatic build_base_tree();
        logic [NODE_W-1:0] par;
        make_root('0, '0);
        for (int i = 1; i < BASE_NODES; i++)
        begin
            par = (i > 1 && $urandom_range(0, 1)) ? NODE_W'(i - 2) : NODE_W'(i - 1);
            link(NODE_W'(i), par);
        end
        for (int i = 0; i < BASE_NODES; i++)
            load_node(NODE_W'(i));
    endtask

    // Rebuild a small tree on random labels at a random base depth, load
    // it in shuffled order, then query inside it (plus the odd outsider).
    task automatic grow_subtree(input int n);
        logic [NODE_W-1:0] members [$];
        logic [NODE_W-1:0] order   [$];
        logic [NODE_W-1:0] cand;
        logic [NODE_W-1:0] par;
        bit                taken;
        while (members.size() < n)
        begin
            cand  = NODE_W'($urandom);
            taken = 0;
            foreach (members[i])
                if (members[i] == cand)
                    taken = 1;
            if (!taken)
                members = {members, cand};
        end
        make_root(members[0], DEPTH_W'($urandom_range(0, NODE_COUNT - 1 - n)));
        for (int j = 1; j < n; j++)
        begin
            // chains most of the time, random branching otherwise
            par = ($urandom_range(0, 2) == 0) ? members[$urandom_range(0, j - 1)]
                                              : members[j-1];
            link(members[j], par);
        end
        order = members;
        order.shuffle();
        foreach (order[i])
            load_node(order[i]);
        repeat ($urandom_range(3, 10))
        begin
            if ($urandom_range(0, 7) == 0)
                ask_pair(members[$urandom_range(0, n - 1)], pick_known());
            else
                ask_pair(members[$urandom_range(0, n - 1)],
                         members[$urandom_range(0, n - 1)]);
        end
        episodes++;
    endtask

    initial
    begin
        int start_items;
        int pick;
        rst_n                = 1'b0;
        steady               = 1'b1;
        req_ch.valid         = 1'b0;
        req_ch.action        = ACT_ANC_WR;
        req_ch.node_a        = '0;
        req_ch.node_b        = '0;
        req_ch.step          = '0;
        req_ch.entry_value   = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Base table fill, no idling to keep it quick
        build_base_tree();

        // Directed corners
        steady = 1'b0;
        send_request(ACT_QUERY, '0, '0, '0, '0);                     // root with itself
        send_request(ACT_QUERY, LAST_NODE, '0, '1, '1);              // deepest vs root
        send_request(ACT_QUERY, '0, LAST_NODE, '0, '1);              // swapped order
        send_request(ACT_QUERY, LAST_NODE, LAST_NODE, '1, '0);       // same node
        send_request(ACT_QUERY, LAST_NODE, LAST_NODE - 1'b1, '0, '0); // bottom neighbors
        send_request(ACT_QUERY, NODE_W'(32), NODE_W'(31), 4'd5, 10'd341);
        send_request(ACT_QUERY, LAST_NODE, climb(LAST_NODE, NODE_COUNT - 1), '0, '0);
        send_request(ACT_QUERY, climb(LAST_NODE - 1'b1, 5), LAST_NODE - 2'd2, '0, '0);
        // ancestor writes past the last level and the unused action: dropped
        send_request(ACT_ANC_WR, LAST_NODE, '0, STEP_W'(JUMP_LEVELS), '1);
        send_request(ACT_ANC_WR, NODE_W'(5), '1, '1, '0);
        send_request(ACT_UNUSED, '1, '1, '1, '1);
        send_request(ACT_UNUSED, '0, '0, '0, '0);
        send_request(ACT_QUERY, LAST_NODE, NODE_W'(5), '0, '0);
        // top depth value breaks the tree: inconsistent depths
        send_request(ACT_DEP_WR, LAST_NODE, '0, '0, '1);
        send_request(ACT_QUERY, LAST_NODE, NODE_W'(40), '0, '0);
        send_request(ACT_QUERY, NODE_W'(3), LAST_NODE, '0, '0);
        send_request(ACT_DEP_WR, LAST_NODE, '1, '0, tree_depth[LAST_NODE]);
        // top jump level pointing at the node itself
        send_request(ACT_ANC_WR, LAST_NODE, '0, STEP_W'(JUMP_LEVELS - 1), LAST_NODE);
        send_request(ACT_QUERY, LAST_NODE, NODE_W'(3), '0, '0);
        send_request(ACT_ANC_WR, LAST_NODE, '0, STEP_W'(JUMP_LEVELS - 1),
                     tree_up[LAST_NODE][JUMP_LEVELS-1]);
        send_request(ACT_QUERY, LAST_NODE - 2'd3, LAST_NODE, '0, '0);
        drain_answers();

        // Random part: mostly subtree rebuilds and queries, some noise
        start_items = useful_items;
        while (useful_items - start_items < RANDOM_ITEMS)
        begin
            steady = ($urandom_range(0, 9) == 0);
            pick   = $urandom_range(0, 99);
            if (pick < 50)
                ask_pair(pick_known(), pick_known());
            else if (pick < 62)
            begin
                if ($urandom_range(0, 7) == 0)
                    grow_subtree($urandom_range(20, 60));
                else
                    grow_subtree($urandom_range(2, 12));
                if ($urandom_range(0, 5) == 0)
                    drain_answers();
            end
            else if (pick < 70)
            begin
                case ($urandom_range(0, 3))
                    0: send_request(ACT_UNUSED, NODE_W'($urandom), NODE_W'($urandom),
                                    STEP_W'($urandom), NODE_W'($urandom));
                    1: send_request(ACT_ANC_WR, NODE_W'($urandom), NODE_W'($urandom),
                                    STEP_W'($urandom_range(JUMP_LEVELS, 15)),
                                    NODE_W'($urandom));
                    2: send_request(ACT_ANC_WR, NODE_W'($urandom), NODE_W'($urandom),
                                    STEP_W'($urandom_range(0, JUMP_LEVELS - 1)),
                                    pick_known());
                    default: send_request(ACT_DEP_WR, NODE_W'($urandom),
                                          NODE_W'($urandom), STEP_W'($urandom),
                                          NODE_W'($urandom));
                endcase
            end
            else
            begin
                // query burst on loaded nodes, with or without idling
                steady = $urandom_range(0, 1);
                repeat ($urandom_range(4, 12))
                    ask_pair(pick_known(), pick_known());
            end
        end

        steady = 1'b0;
        drain_answers();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d loads, %0d queries, %0d subtree rebuilds",
                 requests, loads, queries, episodes);
        $display("checked %0d answers, %0d of them with inconsistent depths",
                 answered, flagged);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
